@@ rtl/wlg_pkg.sv @@
// shared constants, codes and types of the waveform level generator
package wlg_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  localparam int LEVEL_W = 10;
  localparam int MODE_W = 3;
  localparam int TADDR_W = 8;
  localparam int POS_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

  localparam logic [MODE_W-1:0] MODE_TRI_UP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRI_DOWN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SAW = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SINE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOLD = 3'd4;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] rise_step;
    logic [LEVEL_W-1:0] fall_step;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
  } wave_cfg_t;

endpackage

@@ rtl/wlg_table.sv @@
// waveform table memory, one write port and one registered read port
module wlg_table (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [wlg_pkg::ADDR_W-1:0] wr_addr,
  input  logic [wlg_pkg::LEVEL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [wlg_pkg::ADDR_W-1:0] rd_addr,
  output logic [wlg_pkg::LEVEL_W-1:0] rd_data
);
  import wlg_pkg::*;

  logic [LEVEL_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/wlg_level.sv @@
// next level and slope direction for one tick
module wlg_level (
  input  wlg_pkg::wave_cfg_t          cfg,
  input  logic [wlg_pkg::LEVEL_W-1:0] current_level,
  input  logic                        falling,
  input  logic [wlg_pkg::LEVEL_W-1:0] table_data,
  output logic [wlg_pkg::LEVEL_W-1:0] level_next,
  output logic                        falling_next
);
  import wlg_pkg::*;

  logic [LEVEL_W:0] rise_sum;
  logic [LEVEL_W:0] fall_limit;

  assign rise_sum = {1'b0, current_level} + {1'b0, cfg.rise_step};
  assign fall_limit = {1'b0, cfg.min_level} + {1'b0, cfg.fall_step};

  always_comb begin
    level_next = current_level;
    falling_next = falling;
    case (cfg.mode) inside
      MODE_TRI_UP, MODE_TRI_DOWN: begin
        if (!falling) begin
          if (rise_sum >= {1'b0, cfg.max_level}) begin
            level_next = cfg.max_level;
            falling_next = 1'b1;
          end else begin
            level_next = rise_sum[LEVEL_W-1:0];
          end
        end else begin
          if ({1'b0, current_level} <= fall_limit) begin
            level_next = cfg.min_level;
            falling_next = 1'b0;
          end else begin
            level_next = current_level - cfg.fall_step;
          end
        end
      end
      MODE_SAW: begin
        if (rise_sum > {1'b0, cfg.max_level}) begin
          level_next = cfg.min_level;
        end else begin
          level_next = rise_sum[LEVEL_W-1:0];
        end
      end
      MODE_SINE: begin
        level_next = table_data;
      end
      default: begin
        level_next = current_level;
      end
    endcase
  end

endmodule

@@ rtl/waveform_level_generator_top.sv @@
// top level of the waveform level generator
//
//   channel | direction | contents
//   s_*     | in        | tick or table write request
//   m_*     | out       | new converter level
//   cfg_*   | in        | register writes, no read-back
//
// one request per cycle while s_tready is high; a tick request's level passes through
// the first stage, with the registered read of the table memory, and then the output register.
// rst is synchronous and restores register defaults in hold mode.
// a stalled output holds the level; s_tready drops only when both stages are full.
module waveform_level_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wlg_pkg::S_DATA_W-1:0]   s_tdata,   // table_address, table_value, zero pad
  input  logic                           s_tuser,   // operation
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [wlg_pkg::M_DATA_W-1:0]   m_tdata,   // level, zero pad
  input  logic                           cfg_we,
  input  logic [wlg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wlg_pkg::*;

  wave_cfg_t          cfg;
  logic [LEVEL_W-1:0] start_level;
  logic [POS_W-1:0]   table_length;

  logic [LEVEL_W-1:0] current_level;
  logic               falling;
  logic [POS_W-1:0]   table_position;

  logic               v1;
  logic [LEVEL_W-1:0] level;

  logic [TADDR_W-1:0] in_addr;
  logic [LEVEL_W-1:0] in_value;
  logic               advance;
  logic               in_acc;
  logic               is_tick;
  logic               makes_level;
  logic               rd_en;
  logic               wr_en;
  logic [POS_W-1:0]   len_eff;
  logic [POS_W-1:0]   pos_eff;
  logic [LEVEL_W-1:0] rd_data;
  logic [LEVEL_W-1:0] level_next;
  logic               falling_next;

  assign in_addr = s_tdata[TADDR_W-1:0];
  assign in_value = s_tdata[TADDR_W+LEVEL_W-1:TADDR_W];

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance || !v1;
  assign in_acc = s_tvalid && s_tready;
  assign is_tick = (s_tuser == OP_TICK);
  assign makes_level = is_tick && (cfg.mode <= MODE_SINE);
  assign rd_en = in_acc && is_tick && (cfg.mode == MODE_SINE);
  assign wr_en = in_acc && (s_tuser == OP_WRITE) && ({1'b0, in_addr} < DEPTH_POS);

  assign len_eff = (table_length > DEPTH_POS) ? DEPTH_POS : table_length;
  assign pos_eff = (table_position >= len_eff) ? '0 : table_position;

  wlg_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_addr[ADDR_W-1:0]),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (pos_eff[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  wlg_level u_level (
    .cfg           (cfg),
    .current_level (current_level),
    .falling       (falling),
    .table_data    (rd_data),
    .level_next    (level_next),
    .falling_next  (falling_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_HOLD;
      cfg.rise_step <= 10'd16;
      cfg.fall_step <= 10'd16;
      cfg.min_level <= 10'd0;
      cfg.max_level <= 10'd1023;
      start_level <= 10'd0;
      table_length <= DEPTH_POS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg.mode <= cfg_data[MODE_W-1:0];
        REG_RISE_STEP:    cfg.rise_step <= cfg_data;
        REG_FALL_STEP:    cfg.fall_step <= cfg_data;
        REG_MIN_LEVEL:    cfg.min_level <= cfg_data;
        REG_MAX_LEVEL:    cfg.max_level <= cfg_data;
        REG_START_LEVEL:  start_level <= cfg_data;
        REG_TABLE_LENGTH: table_length <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // table position advances when the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      table_position <= '0;
    end else if (cfg_we && cfg_index == REG_MODE) begin
      table_position <= '0;
    end else if (rd_en) begin
      table_position <= pos_eff + POS_W'(1);
    end
  end

  // first stage: request carries a level
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_acc) begin
      v1 <= makes_level;
    end else if (advance) begin
      v1 <= 1'b0;
    end
  end

  // level state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= '0;
      falling <= 1'b0;
    end else if (cfg_we && cfg_index == REG_MODE) begin
      current_level <= start_level;
      falling <= (cfg_data[MODE_W-1:0] == MODE_TRI_DOWN);
    end else if (v1 && advance) begin
      current_level <= level_next;
      falling <= falling_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && advance) begin
      level <= level_next;
    end
  end

  assign m_tdata = {{(M_DATA_W-LEVEL_W){1'b0}}, level};

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    table_position <= DEPTH_POS)
    else $error("table position beyond table depth");

  a_read_to_stage: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> v1)
    else $error("sine request lost after table read");

  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    v1 && advance |=> m_tvalid && m_tdata[LEVEL_W-1:0] == current_level)
    else $error("level not presented after stage advance");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser == OP_WRITE |=> !v1)
    else $error("table write produced a level");

endmodule

@@ dv/waveform_level_generator_top_test.sv @@
// self-checking testbench of the waveform level generator: directed plan, then random phases
`timescale 1ns / 1ps

module waveform_level_generator_top_test;
  import wlg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int RANDOM_PHASES = 20;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    logic [TADDR_W-1:0]    addr;
    logic [LEVEL_W-1:0]    val;
    logic                  typed;
    logic [LEVEL_W-1:0]    lvl;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  s_tuser = OP_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // generator state mirror
  logic [MODE_W-1:0]  gen_mode = MODE_HOLD;
  logic [LEVEL_W-1:0] gen_rise = 10'd16;
  logic [LEVEL_W-1:0] gen_fall = 10'd16;
  logic [LEVEL_W-1:0] gen_min = 10'd0;
  logic [LEVEL_W-1:0] gen_max = 10'd1023;
  logic [LEVEL_W-1:0] gen_start = 10'd0;
  logic [POS_W-1:0]   gen_length = 9'd256;
  logic [LEVEL_W-1:0] gen_level = 10'd0;
  logic               gen_falling = 1'b0;
  logic [POS_W-1:0]   gen_pos = '0;
  logic [LEVEL_W-1:0] wave_mem [TABLE_DEPTH];

  logic [LEVEL_W-1:0] pending_levels [$];
  int level_errors = 0;
  int levels_seen = 0;
  bit no_gaps = 1'b0;
  bit hold_done = 1'b0;

  waveform_level_generator_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // table_address, table_value, zero pad
    .s_tuser(s_tuser),     // operation
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // level, zero pad
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE: begin
        gen_mode = data[MODE_W-1:0];
        gen_level = gen_start;
        gen_pos = '0;
        gen_falling = (gen_mode == MODE_TRI_DOWN);
      end
      REG_RISE_STEP: gen_rise = data;
      REG_FALL_STEP: gen_fall = data;
      REG_MIN_LEVEL: gen_min = data;
      REG_MAX_LEVEL: gen_max = data;
      REG_START_LEVEL: gen_start = data;
      REG_TABLE_LENGTH: gen_length = data[POS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit advance_level(input logic op, input logic [TADDR_W-1:0] addr,
                                       input logic [LEVEL_W-1:0] val,
                                       output logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W:0] sum;
    logic [POS_W-1:0] span;
    lv = '0;
    if (op == OP_WRITE) begin
      wave_mem[addr] = val;
      return 1'b0;
    end
    sum = {1'b0, gen_level} + {1'b0, gen_rise};
    case (gen_mode)
      MODE_TRI_UP, MODE_TRI_DOWN: begin
        if (!gen_falling) begin
          if (sum >= {1'b0, gen_max}) begin
            gen_falling = 1'b1;
            lv = gen_max;
          end else begin
            lv = sum[LEVEL_W-1:0];
          end
        end else if ({1'b0, gen_level} <= {1'b0, gen_min} + {1'b0, gen_fall}) begin
          gen_falling = 1'b0;
          lv = gen_min;
        end else begin
          lv = gen_level - gen_fall;
        end
      end
      MODE_SAW: lv = (sum > {1'b0, gen_max}) ? gen_min : sum[LEVEL_W-1:0];
      MODE_SINE: begin
        span = (gen_length > DEPTH_POS) ? DEPTH_POS : gen_length;
        if (gen_pos >= span) gen_pos = '0;
        lv = wave_mem[gen_pos[TADDR_W-1:0]];
        gen_pos = gen_pos + 1'b1;
      end
      default: return 1'b0;
    endcase
    gen_level = lv;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(input logic op, input logic [TADDR_W-1:0] addr,
                              input logic [LEVEL_W-1:0] val, input logic typed,
                              input logic [LEVEL_W-1:0] typed_level);
    int gap;
    logic [LEVEL_W-1:0] lv;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= S_DATA_W'({val, addr});
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    if (advance_level(op, addr, val, lv)) pending_levels.push_back(typed ? typed_level : lv);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_setting(idx, data);
    @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what, input logic [LEVEL_W-1:0] want,
                                        input logic [LEVEL_W-1:0] got);
    level_errors++;
    if (level_errors <= 10)
      $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic typed, input logic [LEVEL_W-1:0] lvl);
    plan_row_t r;
    r = '0;
    r.op = OP_TICK;
    r.addr = TADDR_W'($urandom);
    r.val = LEVEL_W'($urandom);
    r.typed = typed;
    r.lvl = lvl;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [TADDR_W-1:0] addr,
                                          input logic [LEVEL_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.op = OP_WRITE;
    r.addr = addr;
    r.val = val;
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return LEVEL_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return LEVEL_W'($urandom_range(0, 1023));
    return LEVEL_W'($urandom_range(1, 40));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1;
    if (r == 2) return 10'd256;
    if (r == 3) return 10'd511;
    return CFG_DATA_W'($urandom_range(1, 256));
  endfunction

  // level sink with random back-pressure and one long hold-off
  initial begin
    int run_left;
    logic ready_now;
    run_left = 0;
    ready_now = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(negedge clk);
      if (m_tvalid && m_tready) begin
        levels_seen++;
        if (pending_levels.size() == 0) begin
          note_mismatch("unexpected level", '0, m_tdata[LEVEL_W-1:0]);
        end else if (pending_levels[0] !== m_tdata[LEVEL_W-1:0]) begin
          note_mismatch("level", pending_levels[0], m_tdata[LEVEL_W-1:0]);
          void'(pending_levels.pop_front());
        end else begin
          void'(pending_levels.pop_front());
        end
      end
      if (!hold_done && levels_seen >= 300 && m_tvalid && s_tvalid) begin
        hold_done = 1'b1;
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        @(posedge clk);
      end
      if (run_left == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          ready_now = 1'b1;
          run_left = $urandom_range(1, 24);
        end else begin
          ready_now = 1'b0;
          run_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
      end
      run_left--;
      m_tready <= ready_now;
    end
  end

  initial begin
    plan_row_t plan [];
    logic [MODE_W-1:0] mode_pick;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [LEVEL_W-1:0] swap;
    int count;

    plan = '{
      tick_row(1'b0, '0),
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_TRI_UP)),
      tick_row(1'b1, 10'd16), tick_row(1'b1, 10'd32),
      cfg_row(REG_RISE_STEP, 10'd1023),
      tick_row(1'b1, 10'd1023), tick_row(1'b1, 10'd1007),
      cfg_row(REG_FALL_STEP, 10'd1023),
      tick_row(1'b1, 10'd0),
      cfg_row(REG_START_LEVEL, 10'd1023),
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_TRI_DOWN)),
      tick_row(1'b1, 10'd0), tick_row(1'b0, '0),
      // crossed limits
      cfg_row(REG_MIN_LEVEL, 10'd1023), cfg_row(REG_MAX_LEVEL, 10'd0),
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_SAW)),
      tick_row(1'b1, 10'd1023),
      cfg_row(REG_MIN_LEVEL, 10'd0), cfg_row(REG_MAX_LEVEL, 10'd1023),
      cfg_row(REG_RISE_STEP, 10'd0), cfg_row(REG_MODE, CFG_DATA_W'(MODE_SAW)),
      tick_row(1'b1, 10'd1023),
      cfg_row(REG_RISE_STEP, 10'd1),
      tick_row(1'b1, 10'd0),
      write_row(8'd0, 10'd1023), write_row(8'd1, 10'd0),
      write_row(8'd2, 10'h155), write_row(8'd255, 10'h2AA),
      // zero table length plays entry zero
      cfg_row(REG_TABLE_LENGTH, 10'd0), cfg_row(REG_MODE, CFG_DATA_W'(MODE_SINE)),
      tick_row(1'b1, 10'd1023), tick_row(1'b1, 10'd1023),
      cfg_row(REG_TABLE_LENGTH, 10'd3), cfg_row(REG_MODE, CFG_DATA_W'(MODE_SINE)),
      tick_row(1'b1, 10'd1023), tick_row(1'b1, 10'd0),
      tick_row(1'b1, 10'h155), tick_row(1'b1, 10'd1023),
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_SPARE)), tick_row(1'b0, '0),
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_HOLD)), tick_row(1'b0, '0)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_register(plan[i].idx, plan[i].data);
        cfg_we <= 1'b0;
      end else begin
        send_request(plan[i].op, plan[i].addr, plan[i].val, plan[i].typed, plan[i].lvl);
      end
    end

    // fill the whole table so that any sine read hits a written entry
    for (int a = 0; a < TABLE_DEPTH; a++)
      send_request(OP_WRITE, TADDR_W'(a), LEVEL_W'($urandom), 1'b0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      lo = pick_level();
      hi = pick_level();
      if ($urandom_range(0, 7) != 0 && lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      mode_pick = ($urandom_range(0, 19) < 17) ? MODE_W'($urandom_range(0, 3))
                                                : MODE_W'($urandom_range(4, 7));
      write_register(REG_RISE_STEP, pick_step());
      write_register(REG_FALL_STEP, pick_step());
      write_register(REG_MIN_LEVEL, lo);
      write_register(REG_MAX_LEVEL, hi);
      write_register(REG_START_LEVEL, pick_level());
      write_register(REG_TABLE_LENGTH, pick_length());
      write_register(REG_MODE, CFG_DATA_W'(mode_pick));
      cfg_we <= 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      count = $urandom_range(40, 70);
      repeat (count) begin
        if ($urandom_range(0, 99) < 88)
          send_request(OP_TICK, TADDR_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
        else
          send_request(OP_WRITE, TADDR_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
      end
      no_gaps = 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("** waveform_level_generator_top: PASSED **");
    end else begin
      $display("** waveform_level_generator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** waveform_level_generator_top: FAILED **");
    $finish;
  end

endmodule
